FILE: rtl/hmmt_pkg.sv
// ----------------------------------------------------------------------------
// hmmt_pkg: shared types and constants for the hit-or-miss thinning block
// Holds the image geometry, command codes and the eight 3x3 elements.
// ----------------------------------------------------------------------------
package hmmt_pkg;

   localparam int MaxWidth  = 256;
   localparam int MaxHeight = 256;
   localparam int DimW      = 9;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = $clog2(MaxHeight);
   localparam int AddrW     = ColW + RowW;
   localparam int RoundsW   = 17;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_RUN  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef logic [DimW-1:0] dim_type;

   // care mask and wanted value per element, bit k = row-major entry k
   localparam logic [8:0] ElemCare [8] = '{
      9'b111_010_111, 9'b011_111_110, 9'b101_111_101, 9'b110_111_011,
      9'b111_010_111, 9'b011_111_110, 9'b101_111_101, 9'b110_111_011};
   localparam logic [8:0] ElemWant [8] = '{
      9'b111_010_000, 9'b011_011_000, 9'b001_011_001, 9'b000_011_011,
      9'b000_010_111, 9'b000_110_110, 9'b100_110_100, 9'b110_110_000};

   function automatic dim_type clamp_dim(input logic [31:0] v, input int hi);
      dim_type r;
      if (v < 32'd3) r = dim_type'(3);
      else if (v > 32'(hi)) r = dim_type'(hi);
      else r = v[DimW-1:0];
      return r;
   endfunction

endpackage

FILE: rtl/hit_miss_morphological_thinning.sv
// ----------------------------------------------------------------------------
// hit_miss_morphological_thinning: iterative 8-element hit-or-miss thinning
// Loads a binary image, thins it in place by rounds, and streams it back.
// ----------------------------------------------------------------------------
//  channel   ports                                  direction
//  request   start, busy, req_cmd, req_pixel_in     in (busy out)
//  result    rsp_valid, rsp_pixel_out, rsp_last_pixel, rsp_rounds_done  out
//  config    csr_valid, csr_ready, csr_index, csr_data   in (csr_ready out)
//
// A load request is accepted, then strobed; a read request is accepted,
// reads the image RAM, then is strobed. Run walks the image per element
// with a single 3x3 matcher: a mark pass reads each pixel's 9 neighbors
// from the image RAM, one read a cycle, then drains and writes the mark;
// a clear pass then clears each marked pixel, followed by an element and
// round bookkeeping step. Neighbors are fetched one at a time through the
// single image RAM read port. Pixels are stored at {row, col}.
// Reset clears control state only; the image stores are undefined until
// loaded. The receiver cannot stall: each result is a one-cycle strobe.
// ----------------------------------------------------------------------------
module hit_miss_morphological_thinning (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic [7:0]                    req_pixel_in,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_pixel_out,
   output logic                          rsp_last_pixel,
   output logic [hmmt_pkg::RoundsW-1:0]  rsp_rounds_done,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [31:0]                   csr_data
);
   import hmmt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RDWT  = 3'd1;  // image read settling for read cmd
   localparam logic [2:0] S_MARK  = 3'd2;  // fetch neighbors, mark matches
   localparam logic [2:0] S_CLR   = 3'd3;  // clear marked pixels
   localparam logic [2:0] S_NEXT  = 3'd4;  // element/round bookkeeping
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]          state_ff, state_in;
   dim_type             width_ff, height_ff;
   logic [ColW-1:0]     ld_col_ff, rd_col_ff;
   logic [RowW-1:0]     ld_row_ff, rd_row_ff;
   logic [ColW-1:0]     x_ff;
   logic [RowW-1:0]     y_ff;
   logic [3:0]          k_ff;       // neighbor index 0..8, then drain step 9 and mark-write step 10
   logic [2:0]          elem_ff;
   logic                ok_ff, changed_ff, sub_ff;
   logic [RoundsW-1:0]  rounds_ff;
   logic [7:0]          pix_out_ff;
   logic                last_ff;
   logic [1:0]          cmd_ff;
   logic                kin_ff;     // neighbor in image, aligned with rdata

   logic                img_mem [MaxWidth*MaxHeight];
   logic                mark_mem [MaxWidth*MaxHeight];
   logic                img_rd_ff, mark_rd_ff;
   logic [AddrW-1:0]    img_ra, img_wa;
   logic                img_we, img_wd, mark_we, mark_wd;

   logic                accept;
   logic [1:0]          dy, dx;
   logic [RowW:0]       ny;
   logic [ColW:0]       nx;
   logic                nin;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   // neighbor coordinates for tap k (row-major, center at 4)
   always_comb begin
      dy = 2'd0;
      dx = 2'd0;
      case (k_ff)
         4'd0: begin dy = 2'd0; dx = 2'd0; end
         4'd1: begin dy = 2'd0; dx = 2'd1; end
         4'd2: begin dy = 2'd0; dx = 2'd2; end
         4'd3: begin dy = 2'd1; dx = 2'd0; end
         4'd4: begin dy = 2'd1; dx = 2'd1; end
         4'd5: begin dy = 2'd1; dx = 2'd2; end
         4'd6: begin dy = 2'd2; dx = 2'd0; end
         4'd7: begin dy = 2'd2; dx = 2'd1; end
         4'd8: begin dy = 2'd2; dx = 2'd2; end
         default: begin dy = 2'd1; dx = 2'd1; end
      endcase
      ny  = (RowW+1)'({1'b0, y_ff} + (RowW+1)'(dy)) - (RowW+1)'(1);
      nx  = (ColW+1)'({1'b0, x_ff} + (ColW+1)'(dx)) - (ColW+1)'(1);
      nin = (ny < (RowW+1)'(height_ff)) && (nx < (ColW+1)'(width_ff));
   end

   // image address: row and column side by side
   logic [AddrW-1:0] raddr_rc;
   assign raddr_rc = {ny[RowW-1:0], nx[ColW-1:0]};
   logic [AddrW-1:0] cur_addr;
   assign cur_addr = {y_ff, x_ff};

   always_comb begin
      img_ra  = raddr_rc;
      img_we  = 1'b0;
      img_wa  = cur_addr;
      img_wd  = 1'b0;
      mark_we = 1'b0;
      mark_wd = 1'b0;
      if (state_ff == S_IDLE) begin
         img_ra = {rd_row_ff, rd_col_ff};
         if (accept && req_cmd == CMD_LOAD) begin
            img_we = 1'b1;
            img_wa = {ld_row_ff, ld_col_ff};
            img_wd = (req_pixel_in != 8'hff);
         end
      end else if (state_ff == S_CLR) begin
         img_ra = cur_addr;
         if (sub_ff && mark_rd_ff && img_rd_ff) img_we = 1'b1;
      end else if (state_ff == S_MARK && k_ff == 4'd10) begin
         mark_we = 1'b1;
         mark_wd = ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (img_we) img_mem[img_wa] <= img_wd;
      img_rd_ff <= img_mem[img_ra];
      if (mark_we) mark_mem[cur_addr] <= mark_wd;
      mark_rd_ff <= mark_mem[cur_addr];
   end

   logic last_x, last_y;
   assign last_x = (ColW+1)'(x_ff) == (ColW+1)'(width_ff - dim_type'(1));
   assign last_y = (RowW+1)'(y_ff) == (RowW+1)'(height_ff - dim_type'(1));

   // end of row and end of image for the load and read positions
   logic ld_last_x, ld_last, rd_last_x, rd_last;
   assign ld_last_x = (ColW+1)'(ld_col_ff) == (ColW+1)'(width_ff - dim_type'(1));
   assign ld_last   = ld_last_x &&
                      ((RowW+1)'(ld_row_ff) == (RowW+1)'(height_ff - dim_type'(1)));
   assign rd_last_x = (ColW+1)'(rd_col_ff) == (ColW+1)'(width_ff - dim_type'(1));
   assign rd_last   = rd_last_x &&
                      ((RowW+1)'(rd_row_ff) == (RowW+1)'(height_ff - dim_type'(1)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            case (req_cmd)
               CMD_READ: state_in = S_RDWT;
               CMD_RUN:  state_in = S_MARK;
               default:  state_in = S_RESP;
            endcase
         end
         S_RDWT: state_in = S_RESP;
         S_MARK: if (k_ff == 4'd10 && last_x && last_y) state_in = S_CLR;
         S_CLR:  if (sub_ff && last_x && last_y) state_in = S_NEXT;
         S_NEXT: if (elem_ff == 3'd7 && !changed_ff) state_in = S_RESP;
                 else state_in = S_MARK;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         width_ff    <= dim_type'(MaxWidth);
         height_ff   <= dim_type'(MaxHeight);
         ld_col_ff   <= '0;
         ld_row_ff   <= '0;
         rd_col_ff   <= '0;
         rd_row_ff   <= '0;
         changed_ff  <= 1'b0;
         cmd_ff      <= CMD_LOAD;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WIDTH) width_ff <= clamp_dim(csr_data, MaxWidth);
            else height_ff <= clamp_dim(csr_data, MaxHeight);
            ld_col_ff <= '0;
            ld_row_ff <= '0;
            rd_col_ff <= '0;
            rd_row_ff <= '0;
         end
         if (accept) begin
            cmd_ff <= req_cmd;
            // advance the raster position, wrap after the last pixel
            if (req_cmd == CMD_LOAD) begin
               ld_col_ff <= ld_last_x ? '0 : ld_col_ff + 1'b1;
               if (ld_last_x) ld_row_ff <= ld_last ? '0 : ld_row_ff + 1'b1;
            end
            if (req_cmd == CMD_READ) begin
               rd_col_ff <= rd_last_x ? '0 : rd_col_ff + 1'b1;
               if (rd_last_x) rd_row_ff <= rd_last ? '0 : rd_row_ff + 1'b1;
            end
            changed_ff <= 1'b0;
         end
         if (state_ff == S_CLR && sub_ff && mark_rd_ff && img_rd_ff) changed_ff <= 1'b1;
         if (state_ff == S_NEXT && elem_ff == 3'd7) changed_ff <= 1'b0;
      end
   end

   // sequencer datapath; payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff       <= '0;
         y_ff       <= '0;
         k_ff       <= '0;
         sub_ff     <= 1'b0;
         ok_ff      <= 1'b1;
         elem_ff    <= '0;
         rounds_ff  <= '0;
         pix_out_ff <= 8'd0;
         last_ff    <= (req_cmd == CMD_LOAD) ? ld_last
                     : (req_cmd == CMD_READ) ? rd_last : 1'b0;
      end
      case (state_ff)
         S_RDWT: pix_out_ff <= img_rd_ff ? 8'hff : 8'h00;
         S_MARK: begin
            // taps issue at k 0..8; their registered data is checked at k 1..9
            kin_ff <= nin;
            if (k_ff >= 4'd1 && k_ff <= 4'd9 && ElemCare[elem_ff][k_ff - 4'd1]) begin
               if ((kin_ff & img_rd_ff) != ElemWant[elem_ff][k_ff - 4'd1])
                  ok_ff <= 1'b0;
            end
            if (k_ff == 4'd10) begin
               k_ff  <= '0;
               ok_ff <= 1'b1;
               x_ff  <= last_x ? '0 : x_ff + 1'b1;
               if (last_x) y_ff <= last_y ? '0 : y_ff + 1'b1;
            end else k_ff <= k_ff + 1'b1;
         end
         S_CLR: begin
            sub_ff <= !sub_ff;
            if (sub_ff) begin
               x_ff <= last_x ? '0 : x_ff + 1'b1;
               if (last_x) y_ff <= last_y ? '0 : y_ff + 1'b1;
            end
         end
         S_NEXT: begin
            elem_ff <= elem_ff + 1'b1;
            if (elem_ff == 3'd7 && rounds_ff != {RoundsW{1'b1}})
               rounds_ff <= rounds_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_pixel_out   = (cmd_ff == CMD_READ) ? pix_out_ff : 8'd0;
   assign rsp_last_pixel  = last_ff;
   assign rsp_rounds_done = (cmd_ff == CMD_RUN) ? rounds_ff : '0;

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy) else $error("csr write while busy");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
endmodule
